// ===== hdl/ymr_pkg.sv =====
// Package with the transaction types, codes and CRC function of the YMODEM block receiver.
`timescale 1ns / 1ps

package ymr_pkg;

  localparam int unsigned LONG_BLOCK_BYTES  = 1024;
  localparam int unsigned SHORT_BLOCK_BYTES = 128;

  localparam int unsigned IndexW = 11;

  // Frame lengths include type, sequence, complement and two CRC bytes.
  localparam logic [IndexW-1:0] SHORT_FRAME_LEN = IndexW'(SHORT_BLOCK_BYTES + 5);
  localparam logic [IndexW-1:0] LONG_FRAME_LEN  = IndexW'(LONG_BLOCK_BYTES + 5);
  localparam logic [IndexW-1:0] INDEX_MAX       = {IndexW{1'b1}};

  localparam logic [7:0] SOH_CODE   = 8'h01;
  localparam logic [7:0] STX_CODE   = 8'h02;
  localparam logic [7:0] NUL_CODE   = 8'h00;
  localparam logic [7:0] HDR_CMPL   = 8'hFF;
  localparam logic [7:0] CAN_CODE   = 8'h18;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic [2:0]  CANCEL_RUN = 3'd5;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_BLOCK_OK  = 3'd1,
    KIND_BLOCK_REJ = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_HDR_OK    = 3'd4,
    KIND_HDR_FAIL  = 3'd5,
    KIND_COMPLETE  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_DATA      = 3'd1,
    PH_DONE      = 3'd2,
    PH_CANCELLED = 3'd3,
    PH_FAILED    = 3'd4
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } ymr_in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  data_byte;
    logic [31:0] announced_size;
    logic [31:0] received_total;
    logic [7:0]  block_seq;
  } ymr_out_t;

  // CRC-16/XMODEM update by one byte, most significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/ymodem_block_receiver.sv =====
// YMODEM block receiver: frame checking, size parsing and result output buffer.
`timescale 1ns / 1ps

// The input channel carries one transaction per received byte (func = 0) or per
// idle gap that ends the current frame (func = 1). The output channel carries at
// most one result per input transaction: a streamed payload byte, a block or
// header verdict, a cancel notice or transfer completion.
// Each input transaction is handled in the cycle it is accepted; its result is
// registered in the output register, or in the skid register while that is held.
// The block takes one transaction per cycle while the input is not stalled, as
// the CRC update and the 32-bit size and total arithmetic are combinational.
// When the output is stalled, results are held in the output register and one
// skid register; the input stall rises only when the skid register is full, so
// the input keeps flowing until one more result has been taken after the output
// stalls.
// Reset clears the control state: the block expects header block 0 and the expected
// sequence number is one. After completion, cancel or a failed header, all input
// transactions are taken and dropped until the next reset.
module ymodem_block_receiver
  import ymr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ymr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ymr_out_t out_data_o
);

  phase_e            phase_q, phase_d;
  logic [IndexW-1:0] frame_index_q, frame_index_d;
  logic [IndexW-1:0] frame_length_q, frame_length_d;
  logic [7:0]        expected_seq_q, expected_seq_d;
  logic [15:0]       crc_accum_q, crc_accum_d;
  logic [15:0]       crc_received_q, crc_received_d;
  logic              frame_bad_q, frame_bad_d;
  logic [2:0]        cancel_count_q, cancel_count_d;
  logic              name_done_q, name_done_d;
  logic              size_done_q, size_done_d;
  logic [31:0]       size_value_q, size_value_d;
  logic [31:0]       total_q, total_d;
  logic [7:0]        seq_seen_q, seq_seen_d;

  logic     out_valid_q, skid_valid_q;
  ymr_out_t out_q, skid_q;

  logic        in_accept, out_pop, terminal;
  logic        res_valid;
  ymr_out_t    res;
  logic [7:0]  b;
  logic [35:0] size_mul;
  logic [32:0] total_sum;
  logic        frame_ok;
  logic        cancel_fire;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_pop   = out_valid_q && !out_stall_i;
  assign terminal  = (phase_q == PH_DONE) || (phase_q == PH_CANCELLED) ||
                     (phase_q == PH_FAILED);
  assign b         = in_data_i.rx_byte;

  // size * 10 + digit, as shifts and adds.
  assign size_mul  = {1'b0, size_value_q, 3'b000} + {3'b000, size_value_q, 1'b0} +
                     {32'd0, 4'(b - DIGIT_ZERO)};
  assign total_sum = {1'b0, total_q} + {22'd0, frame_length_q - IndexW'(5)};

  always_comb begin
    phase_d        = phase_q;
    frame_index_d  = frame_index_q;
    frame_length_d = frame_length_q;
    expected_seq_d = expected_seq_q;
    crc_accum_d    = crc_accum_q;
    crc_received_d = crc_received_q;
    frame_bad_d    = frame_bad_q;
    cancel_count_d = cancel_count_q;
    name_done_d    = name_done_q;
    size_done_d    = size_done_q;
    size_value_d   = size_value_q;
    total_d        = total_q;
    seq_seen_d     = seq_seen_q;
    res_valid      = 1'b0;
    res            = '0;
    frame_ok       = 1'b0;
    cancel_fire    = 1'b0;

    if (in_accept && !terminal) begin
      if (!in_data_i.func) begin
        if (frame_index_q != INDEX_MAX) begin
          frame_index_d = frame_index_q + IndexW'(1);
        end
        // A run of cancel bytes counts only from the first byte of a frame.
        if ((phase_q == PH_DATA) && (b == CAN_CODE) &&
            ({8'd0, cancel_count_q} == frame_index_q) && (cancel_count_q < CANCEL_RUN)) begin
          cancel_count_d = cancel_count_q + 3'd1;
          if (cancel_count_d == CANCEL_RUN) begin
            cancel_fire       = 1'b1;
            phase_d           = PH_CANCELLED;
            res_valid         = 1'b1;
            res.result_kind   = KIND_CANCELLED;
          end
        end
        if (!cancel_fire) begin
          if (frame_index_q == IndexW'(0)) begin
            if (b == SOH_CODE) begin
              frame_length_d = SHORT_FRAME_LEN;
            end else if (b == STX_CODE) begin
              frame_length_d = LONG_FRAME_LEN;
            end else begin
              frame_bad_d = 1'b1;
            end
          end else if (frame_index_q == IndexW'(1)) begin
            seq_seen_d = b;
            if ((phase_q == PH_HEADER) && (b != NUL_CODE)) begin
              frame_bad_d = 1'b1;
            end
          end else if (frame_index_q == IndexW'(2)) begin
            if ((phase_q == PH_HEADER) && (b != HDR_CMPL)) begin
              frame_bad_d = 1'b1;
            end
          end else if (!frame_bad_q) begin
            if (frame_index_q < (frame_length_q - IndexW'(2))) begin
              crc_accum_d = crc_byte(crc_accum_q, b);
              if (phase_q == PH_HEADER) begin
                // File name up to its NUL, then the decimal size.
                if (!name_done_q) begin
                  if (b == NUL_CODE) begin
                    name_done_d = 1'b1;
                  end
                end else if (!size_done_q) begin
                  if ((b >= DIGIT_ZERO) && (b <= DIGIT_NINE)) begin
                    size_value_d = (size_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : size_mul[31:0];
                  end else begin
                    size_done_d = 1'b1;
                  end
                end
              end else begin
                res_valid       = 1'b1;
                res.result_kind = KIND_PAYLOAD;
                res.data_byte   = b;
              end
            end else begin
              crc_received_d = {crc_received_q[7:0], b};
            end
          end
        end
      end else if (frame_index_q != IndexW'(0)) begin
        frame_ok  = !frame_bad_q && (frame_index_q == frame_length_q) &&
                    (crc_accum_q == crc_received_q);
        res_valid     = 1'b1;
        res.block_seq = seq_seen_q;
        if (phase_q == PH_HEADER) begin
          if (!(frame_ok && (frame_length_q == SHORT_FRAME_LEN))) begin
            phase_d         = PH_FAILED;
            res.result_kind = KIND_HDR_FAIL;
          end else if (size_value_q == 32'd0) begin
            phase_d         = PH_DONE;
            res.result_kind = KIND_COMPLETE;
          end else begin
            phase_d         = PH_DATA;
            res.result_kind = KIND_HDR_OK;
          end
        end else if (frame_ok && (seq_seen_q == expected_seq_q)) begin
          total_d        = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
          expected_seq_d = expected_seq_q + 8'd1;
          if (total_d >= size_value_q) begin
            phase_d         = PH_DONE;
            res.result_kind = KIND_COMPLETE;
          end else begin
            res.result_kind = KIND_BLOCK_OK;
          end
        end else begin
          res.result_kind = KIND_BLOCK_REJ;
        end
        frame_index_d  = '0;
        frame_length_d = '0;
        crc_accum_d    = '0;
        crc_received_d = '0;
        frame_bad_d    = 1'b0;
        cancel_count_d = '0;
        name_done_d    = 1'b0;
        size_done_d    = 1'b0;
        seq_seen_d     = '0;
      end
    end
    res.announced_size = size_value_d;
    res.received_total = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      frame_index_q  <= '0;
      frame_length_q <= '0;
      expected_seq_q <= 8'd1;
      crc_accum_q    <= '0;
      crc_received_q <= '0;
      frame_bad_q    <= 1'b0;
      cancel_count_q <= '0;
      name_done_q    <= 1'b0;
      size_done_q    <= 1'b0;
      size_value_q   <= '0;
      total_q        <= '0;
      seq_seen_q     <= '0;
    end else begin
      phase_q        <= phase_d;
      frame_index_q  <= frame_index_d;
      frame_length_q <= frame_length_d;
      expected_seq_q <= expected_seq_d;
      crc_accum_q    <= crc_accum_d;
      crc_received_q <= crc_received_d;
      frame_bad_q    <= frame_bad_d;
      cancel_count_q <= cancel_count_d;
      name_done_q    <= name_done_d;
      size_done_q    <= size_done_d;
      size_value_q   <= size_value_d;
      total_q        <= total_d;
      seq_seen_q     <= seq_seen_d;
    end
  end

  // Output register plus one skid entry. The skid entry only fills while the
  // output register is held, and new input is refused while it is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_pop) begin
      out_valid_q <= res_valid;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_pop) begin
      if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE))
    else $error("phase left the completed state");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FAILED) |=> (phase_q == PH_FAILED))
    else $error("phase left the failed-header state");

  a_frame_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_index_q == IndexW'(0)) |-> ((crc_accum_q == 16'd0) && !frame_bad_q))
    else $error("frame state not cleared at the start of a frame");

  a_cancel_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cancel_count_q != 3'd0) |-> ((phase_q == PH_DATA) || (phase_q == PH_CANCELLED)))
    else $error("cancel run counted outside the data phase");

endmodule

// ===== dv/tb_ymodem_block_receiver.sv =====
// Self-checking testbench for the YMODEM block receiver: frame stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb_ymodem_block_receiver;
  import ymr_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int IDLE_PCT       = 9;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 40;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  ymr_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  ymr_out_t out_data_o;

  ymodem_block_receiver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Stimulus-side bookkeeping.
  logic [7:0]  frame_buf[$];
  logic [7:0]  next_seq      = 8'd1;
  logic [31:0] sent_total    = '0;
  logic [31:0] target_size   = '0;
  bit          end_by_cancel = 1'b0;
  bit          idle_on       = 1'b1;
  int          hold_left     = 0;
  int          fail_count    = 0;
  int          stuck_cycles  = 0;

  // Receiver state as predicted from the accepted input transactions.
  phase_e            rx_phase    = PH_HEADER;
  logic [IndexW-1:0] rx_idx      = '0;
  logic [IndexW-1:0] rx_len      = '0;
  logic [7:0]        rx_exp_seq  = 8'd1;
  logic [7:0]        rx_seq      = '0;
  logic [15:0]       rx_crc      = '0;
  logic [15:0]       rx_crc_got  = '0;
  bit                rx_bad      = 1'b0;
  logic [2:0]        rx_can      = '0;
  bit                rx_name_end = 1'b0;
  bit                rx_size_end = 1'b0;
  logic [31:0]       rx_size     = '0;
  logic [31:0]       rx_total    = '0;
  ymr_out_t          result_q[$];
  ymr_out_t          want_res;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic clear_frame_state();
    rx_idx      = '0;
    rx_len      = '0;
    rx_crc      = '0;
    rx_crc_got  = '0;
    rx_bad      = 1'b0;
    rx_can      = '0;
    rx_name_end = 1'b0;
    rx_size_end = 1'b0;
    rx_seq      = '0;
  endtask

  task automatic queue_result(input kind_e k, input logic [7:0] d, input logic [7:0] s);
    ymr_out_t r;
    r.result_kind    = k;
    r.data_byte      = d;
    r.announced_size = rx_size;
    r.received_total = rx_total;
    r.block_seq      = s;
    result_q.push_back(r);
  endtask

  task automatic model_byte(input logic [7:0] b);
    logic [IndexW-1:0] idx;
    logic [63:0]       wide;
    idx = rx_idx;
    if (rx_idx != INDEX_MAX) begin
      rx_idx++;
    end
    // A cancel run only counts while every byte of the frame so far was a cancel code.
    if (rx_phase == PH_DATA && b == CAN_CODE && IndexW'(rx_can) == idx &&
        rx_can < CANCEL_RUN) begin
      rx_can++;
      if (rx_can == CANCEL_RUN) begin
        rx_phase = PH_CANCELLED;
        queue_result(KIND_CANCELLED, 8'd0, 8'd0);
        return;
      end
    end
    if (idx == 0) begin
      if (b == SOH_CODE) begin
        rx_len = SHORT_FRAME_LEN;
      end else if (b == STX_CODE) begin
        rx_len = LONG_FRAME_LEN;
      end else begin
        rx_bad = 1'b1;
      end
    end else if (idx == 1) begin
      rx_seq = b;
      if (rx_phase == PH_HEADER && b != NUL_CODE) begin
        rx_bad = 1'b1;
      end
    end else if (idx == 2) begin
      if (rx_phase == PH_HEADER && b != HDR_CMPL) begin
        rx_bad = 1'b1;
      end
    end else if (!rx_bad) begin
      if (idx < rx_len - IndexW'(2)) begin
        rx_crc = crc16_step(rx_crc, b);
        if (rx_phase == PH_HEADER) begin
          if (!rx_name_end) begin
            rx_name_end = (b == NUL_CODE);
          end else if (!rx_size_end) begin
            if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
              wide    = 64'(rx_size) * 64'd10 + 64'(b - DIGIT_ZERO);
              rx_size = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            end else begin
              rx_size_end = 1'b1;
            end
          end
        end else begin
          queue_result(KIND_PAYLOAD, b, 8'd0);
        end
      end else begin
        rx_crc_got = {rx_crc_got[7:0], b};
      end
    end
  endtask

  task automatic model_gap();
    logic        ok;
    logic [63:0] sum;
    if (rx_idx == 0) begin
      return;
    end
    ok = !rx_bad && rx_idx == rx_len && rx_crc == rx_crc_got;
    if (rx_phase == PH_HEADER) begin
      ok = ok && rx_len == SHORT_FRAME_LEN;
      if (!ok) begin
        rx_phase = PH_FAILED;
        queue_result(KIND_HDR_FAIL, 8'd0, rx_seq);
      end else if (rx_size == 0) begin
        rx_phase = PH_DONE;
        queue_result(KIND_COMPLETE, 8'd0, rx_seq);
      end else begin
        rx_phase = PH_DATA;
        queue_result(KIND_HDR_OK, 8'd0, rx_seq);
      end
    end else if (ok && rx_seq == rx_exp_seq) begin
      sum        = 64'(rx_total) + 64'(rx_len - IndexW'(5));
      rx_total   = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      rx_exp_seq = rx_exp_seq + 8'd1;
      if (rx_total >= rx_size) begin
        rx_phase = PH_DONE;
        queue_result(KIND_COMPLETE, 8'd0, rx_seq);
      end else begin
        queue_result(KIND_BLOCK_OK, 8'd0, rx_seq);
      end
    end else begin
      queue_result(KIND_BLOCK_REJ, 8'd0, rx_seq);
    end
    clear_frame_state();
  endtask

  // Input monitor: every transaction accepted before the transfer ends advances the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o &&
        (rx_phase == PH_HEADER || rx_phase == PH_DATA)) begin
      if (in_data_i.func) begin
        model_gap();
      end else begin
        model_byte(in_data_i.rx_byte);
      end
    end
  end

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result of kind %0d", out_data_o.result_kind));
      end else begin
        want_res = result_q.pop_front();
        if (out_data_o.result_kind !== want_res.result_kind) begin
          report_mismatch($sformatf("result_kind %0d, expected %0d",
                                    out_data_o.result_kind, want_res.result_kind));
        end
        if (out_data_o.data_byte !== want_res.data_byte) begin
          report_mismatch($sformatf("data_byte %h, expected %h",
                                    out_data_o.data_byte, want_res.data_byte));
        end
        if (out_data_o.announced_size !== want_res.announced_size) begin
          report_mismatch($sformatf("announced_size %0d, expected %0d",
                                    out_data_o.announced_size, want_res.announced_size));
        end
        if (out_data_o.received_total !== want_res.received_total) begin
          report_mismatch($sformatf("received_total %0d, expected %0d",
                                    out_data_o.received_total, want_res.received_total));
        end
        if (out_data_o.block_seq !== want_res.block_seq) begin
          report_mismatch($sformatf("block_seq %0d, expected %0d",
                                    out_data_o.block_seq, want_res.block_seq));
        end
      end
    end
  end

  // Result side: random stall, or a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    ymr_in_t it;
    it.func    = f;
    it.rx_byte = b;
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_gap();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic start_frame(input logic [7:0] typ, input logic [7:0] seqv,
                             input logic [7:0] cmpl);
    frame_buf.delete();
    frame_buf.push_back(typ);
    frame_buf.push_back(seqv);
    frame_buf.push_back(cmpl);
  endtask

  task automatic add_random_body(input int n);
    repeat (n) begin
      frame_buf.push_back(8'($urandom));
    end
  endtask

  task automatic add_crc();
    logic [15:0] c;
    c = '0;
    for (int i = 3; i < frame_buf.size(); i++) begin
      c = crc16_step(c, frame_buf[i]);
    end
    frame_buf.push_back(c[15:8]);
    frame_buf.push_back(c[7:0]);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) begin
      send_item(1'b0, frame_buf[i]);
    end
    send_gap();
  endtask

  task automatic build_good_block(input bit long_blk);
    start_frame(long_blk ? STX_CODE : SOH_CODE, next_seq, ~next_seq);
    add_random_body(long_blk ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES);
    add_crc();
  endtask

  task automatic note_accepted(input bit long_blk);
    next_seq   = next_seq + 8'd1;
    sent_total = sent_total + (long_blk ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES);
  endtask

  task automatic send_good_block(input bit long_blk);
    build_good_block(long_blk);
    send_frame();
    note_accepted(long_blk);
  endtask

  task automatic test_empty_gap_after_reset();
    send_gap();
    send_gap();
  endtask

  task automatic test_header();
    string digits;
    logic [7:0] term_opts[4];
    term_opts = '{NUL_CODE, 8'h20, DIGIT_ZERO - 8'd1, DIGIT_NINE + 8'd1};
    // A cancel ending leaves the size near or past the 32-bit limit; otherwise one
    // short block reaches the announced size.
    if (end_by_cancel) begin
      target_size = '1;
      digits      = $sformatf("%0d", 64'd4294967290 + 64'($urandom_range(9)));
    end else begin
      target_size = $urandom_range(1, SHORT_BLOCK_BYTES);
      digits      = $sformatf("%0d", target_size);
    end
    if ($urandom_range(1)) begin
      digits = {"00", digits};
    end
    start_frame(SOH_CODE, NUL_CODE, HDR_CMPL);
    repeat ($urandom_range(1, 16)) begin
      frame_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
    frame_buf.push_back(NUL_CODE);
    for (int i = 0; i < digits.len(); i++) begin
      frame_buf.push_back(digits[i]);
    end
    frame_buf.push_back(term_opts[$urandom_range(3)]);
    while (frame_buf.size() < 3 + SHORT_BLOCK_BYTES) begin
      frame_buf.push_back(8'($urandom));
    end
    add_crc();
    send_frame();
  endtask

  task automatic test_rejected_frames();
    // Long type byte in front of a short body: the bytes stream, then a reject.
    start_frame(STX_CODE, next_seq, ~next_seq);
    add_random_body(20);
    send_frame();
    start_frame(8'h55, next_seq, ~next_seq);
    add_random_body(10);
    send_frame();
    send_item(1'b0, SOH_CODE);
    send_gap();
    send_item(1'b0, SOH_CODE);
    send_item(1'b0, next_seq);
    send_gap();
    send_gap();
    // Four cancel codes, then other bytes: not a cancel.
    frame_buf.delete();
    repeat (4) frame_buf.push_back(CAN_CODE);
    frame_buf.push_back(SOH_CODE);
    add_random_body(6);
    send_frame();
    // Cancel codes that do not open the frame do not count.
    start_frame(SOH_CODE, CAN_CODE, CAN_CODE);
    repeat (8) frame_buf.push_back(CAN_CODE);
    send_frame();
  endtask

  task automatic test_output_hold_off();
    hold_left = HOLD_CYCLES;
    if ($urandom_range(1)) begin
      // Only the top bit of the sequence byte is wrong; the block must not match.
      start_frame(SOH_CODE, next_seq ^ 8'h80, ~(next_seq ^ 8'h80));
      add_random_body(SHORT_BLOCK_BYTES);
      add_crc();
    end else begin
      build_good_block(1'b0);
      frame_buf[frame_buf.size() - 1] ^= 8'(1 << $urandom_range(7));
    end
    send_frame();
  endtask

  task automatic test_random_frames();
    int sent;
    int pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(2);
      if (pick == 0) begin
        // A run of cancel codes too short to cancel, broken by another byte.
        frame_buf.delete();
        repeat ($urandom_range(0, 4)) frame_buf.push_back(CAN_CODE);
        frame_buf.push_back(8'($urandom_range(0, int'(CAN_CODE) - 1)));
      end else begin
        start_frame((pick == 1) ? SOH_CODE : STX_CODE, 8'($urandom), 8'($urandom));
      end
      add_random_body($urandom_range(0, 6));
      sent += frame_buf.size() + 1;
      send_frame();
    end
  endtask

  task automatic test_good_block();
    // No idling on either side for the whole block.
    idle_on = 1'b0;
    build_good_block(1'b0);
    if ($urandom_range(1)) begin
      // The complement byte of a data block is not checked.
      frame_buf[2] = 8'($urandom);
    end
    send_frame();
    note_accepted(1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_finish();
    if (end_by_cancel) begin
      repeat (5) send_item(1'b0, CAN_CODE);
    end else begin
      while (sent_total < target_size) begin
        send_good_block(1'b0);
      end
    end
    // Everything after the end of the transfer is dropped without a result.
    repeat (10) begin
      send_item(1'($urandom_range(1)), 8'($urandom));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    end_by_cancel = 1'($urandom_range(1));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_gap_after_reset();
    test_header();
    test_rejected_frames();
    test_output_hold_off();
    test_random_frames();
    test_good_block();
    test_finish();
    @(posedge clk_i);
    while (result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", result_q.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
